FILE: rtl/ktcl_pkg.sv
// ktcl_pkg: shared types and codes for the keypad/tag code lock.
// Used by the channel interfaces, the register block and the top level.
`timescale 1ns / 1ps

package ktcl_pkg;

   localparam int KEY_W     = 4;
   localparam int TAG_W     = 32;
   localparam int SCREEN_W  = 4;
   localparam int VERDICT_W = 4;
   localparam int COUNT_W   = 4;
   localparam int ENTRY_W   = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // key codes
   localparam logic [KEY_W-1:0] KEY_ZERO = 4'd0;
   localparam logic [KEY_W-1:0] KEY_ONE  = 4'd1;
   localparam logic [KEY_W-1:0] KEY_TWO  = 4'd2;
   localparam logic [KEY_W-1:0] KEY_NINE = 4'd9;
   localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
   localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

   // item kinds
   localparam logic OP_KEY = 1'b0;
   localparam logic OP_TAG = 1'b1;

   // screen codes
   localparam logic [SCREEN_W-1:0] SCR_HOME       = 4'd0;
   localparam logic [SCREEN_W-1:0] SCR_CODE_ENTRY = 4'd1;
   localparam logic [SCREEN_W-1:0] SCR_TAG_WAIT   = 4'd2;
   localparam logic [SCREEN_W-1:0] SCR_MENU_CODE  = 4'd3;
   localparam logic [SCREEN_W-1:0] SCR_MENU_LEVEL = 4'd4;
   localparam logic [SCREEN_W-1:0] SCR_MENU_RESET = 4'd5;
   localparam logic [SCREEN_W-1:0] SCR_NEW_CODE   = 4'd6;
   localparam logic [SCREEN_W-1:0] SCR_LEVEL_SEL  = 4'd7;
   localparam logic [SCREEN_W-1:0] SCR_MASTER     = 4'd8;

   // verdict codes
   localparam logic [VERDICT_W-1:0] V_NONE        = 4'd0;
   localparam logic [VERDICT_W-1:0] V_GRANTED     = 4'd1;
   localparam logic [VERDICT_W-1:0] V_DENIED      = 4'd2;
   localparam logic [VERDICT_W-1:0] V_TAG_OK      = 4'd3;
   localparam logic [VERDICT_W-1:0] V_CODE_UPD    = 4'd4;
   localparam logic [VERDICT_W-1:0] V_WRONG_CODE  = 4'd5;
   localparam logic [VERDICT_W-1:0] V_LEVEL_SET   = 4'd6;
   localparam logic [VERDICT_W-1:0] V_RESET_DONE  = 4'd7;
   localparam logic [VERDICT_W-1:0] V_INVALID_TAG = 4'd8;

   // security levels and menu options
   localparam logic [1:0] LVL_TAG_ONLY  = 2'd0;
   localparam logic [1:0] LVL_CODE_ONLY = 2'd1;
   localparam logic [1:0] LVL_DUAL      = 2'd2;
   localparam logic [1:0] OPT_CODE      = 2'd0;
   localparam logic [1:0] OPT_LEVEL     = 2'd1;
   localparam logic [1:0] OPT_RESET     = 2'd2;

   // register indexes (paddr[2])
   localparam logic REG_ENROLLED_TAG = 1'b0;
   localparam logic REG_MASTER_CODE  = 1'b1;

   localparam logic [CSR_DATA_W-1:0] ENROLLED_TAG_RESET = 32'h57F0_EC4E;
   localparam logic [CSR_DATA_W-1:0] MASTER_CODE_RESET  = 32'h1111_1111;

   typedef struct packed {
      logic [TAG_W-1:0]      enrolled_tag;
      logic [CSR_DATA_W-1:0] master_code;
   } cfg_type;

endpackage

FILE: rtl/ktcl_req_if.sv
// ktcl_req_if: input item channel (key press or tag read).
// Depends on ktcl_pkg for field widths.
`timescale 1ns / 1ps

interface ktcl_req_if import ktcl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             operation;
   logic [KEY_W-1:0] key_code;
   logic [TAG_W-1:0] tag_uid;

   modport source (output valid, operation, key_code, tag_uid, input ready);
   modport sink   (input valid, operation, key_code, tag_uid, output ready);
endinterface

FILE: rtl/ktcl_rsp_if.sv
// ktcl_rsp_if: result item channel (lock flag, screen, verdict, digit count).
// Depends on ktcl_pkg for field widths.
`timescale 1ns / 1ps

interface ktcl_rsp_if import ktcl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 locked;
   logic [SCREEN_W-1:0]  screen;
   logic [VERDICT_W-1:0] verdict;
   logic [COUNT_W-1:0]   digits_entered;

   modport source (output valid, locked, screen, verdict, digits_entered, input ready);
   modport sink   (input valid, locked, screen, verdict, digits_entered, output ready);
endinterface

FILE: rtl/ktcl_csr.sv
// ktcl_csr: APB-style register block holding the enrolled tag and master code.
// Depends on ktcl_pkg.
`timescale 1ns / 1ps

module ktcl_csr import ktcl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [TAG_W-1:0]      tag_ff;
   logic [CSR_DATA_W-1:0] master_ff;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff    <= ENROLLED_TAG_RESET;
         master_ff <= MASTER_CODE_RESET;
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_ENROLLED_TAG: tag_ff    <= csr_pwdata;
            REG_MASTER_CODE:  master_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ENROLLED_TAG: csr_prdata = tag_ff;
         REG_MASTER_CODE:  csr_prdata = master_ff;
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.enrolled_tag = tag_ff;
   assign cfg.master_code  = master_ff;

endmodule

FILE: rtl/keypad_tag_code_lock.sv
// keypad_tag_code_lock: door access controller stepped by key presses and tag reads.
// Depends on ktcl_pkg, ktcl_req_if, ktcl_rsp_if and ktcl_csr.
//
//   port      dir    handshake              carries
//   req       sink   valid/ready            operation, key_code, tag_uid
//   rsp       source valid/ready            locked, screen, verdict, digits_entered
//   csr_*     slave  psel/penable, pready=1 enrolled_tag (0x0), master_code (0x4)
//
// Every item yields one result, held in the result register loaded on acceptance.
// One item per cycle while rsp is not stalled: the whole state update is one pass of next-state logic.
// req.ready is high whenever the result register is empty or being drained.
// Synchronous reset: unlocked home screen, code all ones, level 2.
`timescale 1ns / 1ps

module keypad_tag_code_lock import ktcl_pkg::*; #(
   parameter int CODE_DIGITS   = 6,
   parameter int MASTER_DIGITS = 8,
   parameter int TAG_BYTES     = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   ktcl_req_if.sink              req,
   ktcl_rsp_if.source            rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CODE_W   = 4 * CODE_DIGITS;
   localparam int MASTER_W = 4 * MASTER_DIGITS;
   localparam int TAGCMP_W = 8 * TAG_BYTES;

   typedef enum logic [3:0] {
      PH_HOME, PH_LOCK_CODE, PH_LOCK_TAG, PH_MENU, PH_OLD_CODE,
      PH_NEW_CODE, PH_LVL_CODE, PH_LVL_TAG, PH_LVL_SELECT, PH_MASTER
   } phase_type;

   cfg_type cfg;

   ktcl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   phase_type            phase_ff, phase_in;
   logic                 locked_ff, locked_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [1:0]           level_ff, level_in;
   logic [1:0]           option_ff, option_in;
   logic [ENTRY_W-1:0]   entry_ff, entry_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_locked_ff;
   logic [SCREEN_W-1:0]  rsp_screen_ff, screen_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff, verdict_in;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 accept;
   logic                 tag_phase;
   logic                 is_digit;
   logic [ENTRY_W-1:0]   entry_shift;
   logic [COUNT_W-1:0]   count_inc;
   logic                 code_done, master_done;
   logic                 code_match, master_match, tag_match;
   phase_type            lock_wait;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign tag_phase   = (phase_ff == PH_LOCK_TAG) || (phase_ff == PH_LVL_TAG);
   assign is_digit    = req.key_code <= KEY_NINE;
   assign entry_shift = {entry_ff[ENTRY_W-5:0], req.key_code};
   assign count_inc   = count_ff + COUNT_W'(1);
   assign code_done   = is_digit && (count_inc >= COUNT_W'(CODE_DIGITS));
   assign master_done = is_digit && (count_inc >= COUNT_W'(MASTER_DIGITS));
   assign code_match  = entry_shift[CODE_W-1:0] == code_ff;
   assign master_match = entry_shift[MASTER_W-1:0] ==
                         cfg.master_code[CSR_DATA_W-1 -: MASTER_W];
   assign tag_match   = req.tag_uid[TAG_W-1 -: TAGCMP_W] ==
                        cfg.enrolled_tag[TAG_W-1 -: TAGCMP_W];
   assign lock_wait   = (level_ff == LVL_CODE_ONLY) ? PH_LOCK_CODE : PH_LOCK_TAG;

   always_comb begin
      phase_in   = phase_ff;
      locked_in  = locked_ff;
      code_in    = code_ff;
      level_in   = level_ff;
      option_in  = option_ff;
      entry_in   = entry_ff;
      count_in   = count_ff;
      verdict_in = V_NONE;

      if (req.operation == OP_KEY && !tag_phase) begin
         case (phase_ff)
            PH_HOME: begin
               if (req.key_code == KEY_ONE) begin
                  phase_in  = PH_MENU;
                  option_in = OPT_CODE;
               end else if (req.key_code == KEY_HASH) begin
                  locked_in = 1'b1;
                  phase_in  = lock_wait;
               end
            end
            PH_LOCK_CODE, PH_OLD_CODE, PH_NEW_CODE, PH_LVL_CODE: begin
               if (is_digit) begin
                  entry_in = entry_shift;
                  count_in = count_inc;
               end
               if (code_done) begin
                  entry_in = '0;
                  count_in = '0;
                  case (phase_ff)
                     PH_LOCK_CODE: begin
                        if (code_match) begin
                           verdict_in = V_GRANTED;
                           locked_in  = 1'b0;
                           phase_in   = PH_HOME;
                        end else begin
                           verdict_in = V_DENIED;
                           phase_in   = lock_wait;
                        end
                     end
                     PH_OLD_CODE: begin
                        if (code_match) begin
                           phase_in = PH_NEW_CODE;
                        end else begin
                           verdict_in = V_WRONG_CODE;
                           phase_in   = PH_MENU;
                           option_in  = OPT_CODE;
                        end
                     end
                     PH_NEW_CODE: begin
                        code_in    = entry_shift[CODE_W-1:0];
                        verdict_in = V_CODE_UPD;
                        phase_in   = PH_MENU;
                        option_in  = OPT_CODE;
                     end
                     default: begin
                        // level change: code first, then a tag at the dual level
                        if (code_match) begin
                           phase_in = (level_ff >= LVL_DUAL) ? PH_LVL_TAG : PH_LVL_SELECT;
                        end else begin
                           verdict_in = V_WRONG_CODE;
                           phase_in   = PH_MENU;
                           option_in  = OPT_LEVEL;
                        end
                     end
                  endcase
               end
            end
            PH_MENU: begin
               case (option_ff)
                  OPT_CODE: begin
                     if (req.key_code == KEY_STAR) phase_in = PH_HOME;
                     else if (req.key_code == KEY_ZERO) phase_in = PH_OLD_CODE;
                     else if (req.key_code == KEY_HASH) option_in = OPT_LEVEL;
                  end
                  OPT_LEVEL: begin
                     if (req.key_code == KEY_STAR) option_in = OPT_CODE;
                     else if (req.key_code == KEY_ZERO) phase_in = PH_LVL_CODE;
                     else if (req.key_code == KEY_HASH) option_in = OPT_RESET;
                  end
                  default: begin
                     if (req.key_code == KEY_STAR) option_in = OPT_LEVEL;
                     else if (req.key_code == KEY_ZERO) phase_in = PH_MASTER;
                     else if (req.key_code == KEY_HASH) option_in = OPT_RESET;
                  end
               endcase
            end
            PH_LVL_SELECT: begin
               if (req.key_code <= KEY_TWO) begin
                  level_in   = req.key_code[1:0];
                  verdict_in = V_LEVEL_SET;
                  phase_in   = PH_MENU;
                  option_in  = OPT_LEVEL;
               end
            end
            PH_MASTER: begin
               if (is_digit) begin
                  entry_in = entry_shift;
                  count_in = count_inc;
               end
               if (master_done) begin
                  if (master_match) begin
                     code_in    = {CODE_DIGITS{4'h1}};
                     level_in   = LVL_DUAL;
                     verdict_in = V_RESET_DONE;
                  end else begin
                     verdict_in = V_DENIED;
                  end
                  phase_in  = PH_MENU;
                  option_in = OPT_RESET;
                  entry_in  = '0;
                  count_in  = '0;
               end
            end
            default: ;
         endcase
      end else if (req.operation == OP_TAG && tag_phase) begin
         if (phase_ff == PH_LOCK_TAG) begin
            if (!tag_match) begin
               verdict_in = V_DENIED;
            end else if (level_ff == LVL_TAG_ONLY) begin
               verdict_in = V_GRANTED;
               locked_in  = 1'b0;
               phase_in   = PH_HOME;
            end else begin
               verdict_in = V_TAG_OK;
               phase_in   = PH_LOCK_CODE;
            end
         end else begin
            if (tag_match) begin
               phase_in = PH_LVL_SELECT;
            end else begin
               verdict_in = V_INVALID_TAG;
               phase_in   = PH_MENU;
               option_in  = OPT_LEVEL;
            end
         end
      end
   end

   always_comb begin
      case (phase_in)
         PH_HOME:                               screen_in = SCR_HOME;
         PH_LOCK_CODE, PH_OLD_CODE, PH_LVL_CODE: screen_in = SCR_CODE_ENTRY;
         PH_LOCK_TAG, PH_LVL_TAG:               screen_in = SCR_TAG_WAIT;
         PH_MENU: begin
            case (option_in)
               OPT_CODE:  screen_in = SCR_MENU_CODE;
               OPT_LEVEL: screen_in = SCR_MENU_LEVEL;
               default:   screen_in = SCR_MENU_RESET;
            endcase
         end
         PH_NEW_CODE:   screen_in = SCR_NEW_CODE;
         PH_LVL_SELECT: screen_in = SCR_LEVEL_SEL;
         PH_MASTER:     screen_in = SCR_MASTER;
         default:       screen_in = SCR_HOME;
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HOME;
         locked_ff    <= 1'b0;
         code_ff      <= {CODE_DIGITS{4'h1}};
         level_ff     <= LVL_DUAL;
         option_ff    <= OPT_CODE;
         entry_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            locked_ff <= locked_in;
            code_ff   <= code_in;
            level_ff  <= level_in;
            option_ff <= option_in;
            entry_ff  <= entry_in;
            count_ff  <= count_in;
         end
      end
      if (accept) begin
         rsp_locked_ff  <= locked_in;
         rsp_screen_ff  <= screen_in;
         rsp_verdict_ff <= verdict_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.locked         = rsp_locked_ff;
   assign rsp.screen         = rsp_screen_ff;
   assign rsp.verdict        = rsp_verdict_ff;
   assign rsp.digits_entered = rsp_count_ff;

   // the door is only ever locked while waiting for a code or a tag
   a_locked_phase: assert property (@(posedge clock) disable iff (reset)
      locked_ff |-> (phase_ff == PH_LOCK_CODE || phase_ff == PH_LOCK_TAG))
      else $error("locked outside an unlock phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff < COUNT_W'(CODE_DIGITS)) || (count_ff < COUNT_W'(MASTER_DIGITS)))
      else $error("digit count past entry length");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_DUAL)
      else $error("security level out of range");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_granted_unlocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_verdict_ff == V_GRANTED) |-> !rsp_locked_ff)
      else $error("grant reported with door locked");

endmodule
